// ===== rtl/vmmu_pkg.sv =====
// Package: widths, operating modes and saturating add for the vector MAC unit.
package vmmu_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned PROD_BITS   = 2 * SAMPLE_BITS + 1;
  localparam int unsigned ACC_BITS    = 40;
  localparam int unsigned OUT_BITS    = 40;
  localparam int unsigned MODE_BITS   = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_RMUL = 2'd0,
    MODE_CMUL = 2'd1,
    MODE_RDOT = 2'd2,
    MODE_CDOT = 2'd3
  } mode_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [OUT_BITS-1:0]    res_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // Two's complement add clamped to the accumulator range.
  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic signed [ACC_BITS:0] sum;
    acc_t                     r;
    sum = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      r = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      r = sum[ACC_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/vmmu_in_if.sv =====
// Interface: input channel carrying one element pair per word.
interface vmmu_in_if;
  logic                 valid;
  logic                 ready;
  vmmu_pkg::sample_t    a_re;
  vmmu_pkg::sample_t    a_im;
  vmmu_pkg::sample_t    b_re;
  vmmu_pkg::sample_t    b_im;
  logic                 last;

  modport source (output valid, a_re, a_im, b_re, b_im, last, input ready);
  modport sink   (input valid, a_re, a_im, b_re, b_im, last, output ready);
endinterface

// ===== rtl/vmmu_out_if.sv =====
// Interface: result channel carrying one product or dot sum per word.
interface vmmu_out_if;
  logic           valid;
  logic           ready;
  vmmu_pkg::res_t res_re;
  vmmu_pkg::res_t res_im;
  logic           end_of_vector;

  modport source (output valid, res_re, res_im, end_of_vector, input ready);
  modport sink   (input valid, res_re, res_im, end_of_vector, output ready);
endinterface

// ===== rtl/vmmu_cfg_if.sv =====
// Interface: configuration write channel for the mode register.
interface vmmu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vmmu_pkg::MODE_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/vector_mac_multiply_unit_top.sv =====
// Top level: real/complex multiply and saturating dot-product accumulator.
//
//  channel   dir  word contents                         handshake
//  cfg_i     in   data: mode (2 bits)                   valid/ready, ready tied high
//  in_i      in   a_re a_im b_re b_im (Q1.15), last     valid/ready
//  out_o     out  res_re res_im (Q.30, 40b), end_of_vector  valid/ready
//
// One word per cycle sustained while out_o is not stalled; the input word passes
// the input register, then four 16x16 multipliers, the complex-mode add and subtract
// and, in dot modes, the 40-bit saturating accumulate into the result register.
// Dot modes give a result only on the last element, then clear both sums.
// Reset clears mode, accumulators and valid flags; no clearing pass needed.
// A stall on out_o holds the result register and backs up into in_i.ready.
module vector_mac_multiply_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  vmmu_cfg_if.sink    cfg_i,
  vmmu_in_if.sink     in_i,
  vmmu_out_if.source  out_o
);

  vmmu_pkg::mode_e   mode_q;

  logic              s1_valid_q;
  vmmu_pkg::sample_t a_re_q, a_im_q, b_re_q, b_im_q;
  logic              last_q;

  vmmu_pkg::acc_t    acc_re_q, acc_re_d;
  vmmu_pkg::acc_t    acc_im_q, acc_im_d;

  logic              out_valid_q, out_valid_d;
  vmmu_pkg::res_t    res_re_q, res_re_d;
  vmmu_pkg::res_t    res_im_q, res_im_d;
  logic              eov_q;

  logic signed [2*vmmu_pkg::SAMPLE_BITS-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [vmmu_pkg::PROD_BITS-1:0]     pre, pim;
  vmmu_pkg::acc_t    pre_ext, pim_ext, acc_re_sum, acc_im_sum;

  logic              is_cplx, is_dot, emit, s1_adv, in_acc;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vmmu_pkg::MODE_RMUL;
    end else if (cfg_i.valid) begin
      mode_q <= vmmu_pkg::mode_e'(cfg_i.data);
    end
  end

  // Datapath
  assign is_cplx = (mode_q == vmmu_pkg::MODE_CMUL) || (mode_q == vmmu_pkg::MODE_CDOT);
  assign is_dot  = (mode_q == vmmu_pkg::MODE_RDOT) || (mode_q == vmmu_pkg::MODE_CDOT);

  assign p_rr = a_re_q * b_re_q;
  assign p_ii = a_im_q * b_im_q;
  assign p_ir = a_im_q * b_re_q;
  assign p_ri = a_re_q * b_im_q;

  always_comb begin
    if (is_cplx) begin
      pre = vmmu_pkg::PROD_BITS'(p_rr) - vmmu_pkg::PROD_BITS'(p_ii);
      pim = vmmu_pkg::PROD_BITS'(p_ir) + vmmu_pkg::PROD_BITS'(p_ri);
    end else begin
      pre = vmmu_pkg::PROD_BITS'(p_rr);
      pim = '0;
    end
  end

  assign pre_ext    = vmmu_pkg::ACC_BITS'(pre);
  assign pim_ext    = vmmu_pkg::ACC_BITS'(pim);
  assign acc_re_sum = vmmu_pkg::sat_add(acc_re_q, pre_ext);
  assign acc_im_sum = vmmu_pkg::sat_add(acc_im_q, pim_ext);

  // Flow control: a dot-mode word that is not last never needs the output slot.
  assign emit        = !is_dot || last_q;
  assign s1_adv      = s1_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_re_q <= in_i.a_re;
      a_im_q <= in_i.a_im;
      b_re_q <= in_i.b_re;
      b_im_q <= in_i.b_im;
      last_q <= in_i.last;
    end
  end

  always_comb begin
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_re_d    = res_re_q;
    res_im_d    = res_im_q;
    if (s1_adv && is_dot) begin
      if (last_q) begin
        acc_re_d = '0;
        acc_im_d = '0;
      end else begin
        acc_re_d = acc_re_sum;
        if (is_cplx) begin
          acc_im_d = acc_im_sum;
        end
      end
    end
    if (s1_adv && emit) begin
      out_valid_d = 1'b1;
      if (is_dot) begin
        res_re_d = vmmu_pkg::OUT_BITS'(acc_re_sum);
        res_im_d = is_cplx ? vmmu_pkg::OUT_BITS'(acc_im_sum) : '0;
      end else begin
        res_re_d = vmmu_pkg::OUT_BITS'(pre_ext);
        res_im_d = vmmu_pkg::OUT_BITS'(pim_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    if (s1_adv && emit) begin
      eov_q <= last_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.res_re        = res_re_q;
  assign out_o.res_im        = res_im_q;
  assign out_o.end_of_vector = eov_q;

endmodule

// ===== rtl/vmmu_checker.sv =====
// Checker: port-level properties of the vector MAC unit, bound to the top level.
module vmmu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_i,
  input logic [vmmu_pkg::MODE_BITS-1:0] cfg_data_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input vmmu_pkg::res_t                 res_re_i,
  input vmmu_pkg::res_t                 res_im_i,
  input logic                           end_of_vector_i
);

  vmmu_pkg::mode_e mode_q;
  logic            real_mode, dot_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vmmu_pkg::MODE_RMUL;
    end else if (cfg_valid_i && cfg_ready_i) begin
      mode_q <= vmmu_pkg::mode_e'(cfg_data_i);
    end
  end

  assign real_mode = (mode_q == vmmu_pkg::MODE_RMUL) || (mode_q == vmmu_pkg::MODE_RDOT);
  assign dot_mode  = (mode_q == vmmu_pkg::MODE_RDOT) || (mode_q == vmmu_pkg::MODE_CDOT);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_re_i) && $stable(res_im_i)
      && $stable(end_of_vector_i))
    else $error("result word changed while stalled");

  // Real modes never produce an imaginary part.
  a_real_im_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && real_mode |-> res_im_i == '0)
    else $error("nonzero imaginary result in a real mode");

  // Dot modes only report at the end of a vector.
  a_dot_eov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dot_mode |-> end_of_vector_i)
    else $error("dot-mode result without end of vector");

  // A single real product is bounded by 2^30 in magnitude.
  a_rmul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (mode_q == vmmu_pkg::MODE_RMUL) |->
      res_re_i[vmmu_pkg::OUT_BITS-1:31] == '0 || res_re_i[vmmu_pkg::OUT_BITS-1:30] == '1)
    else $error("real product out of Q2.30 range");

endmodule

bind vector_mac_multiply_unit_top vmmu_checker u_vmmu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_i.valid),
  .cfg_ready_i     (cfg_i.ready),
  .cfg_data_i      (cfg_i.data),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .res_re_i        (out_o.res_re),
  .res_im_i        (out_o.res_im),
  .end_of_vector_i (out_o.end_of_vector)
);

// ===== sim/tb_vector_mac_multiply_unit_top.sv =====
// Testbench: directed and random element streams through the vector MAC unit.
module tb_vector_mac_multiply_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                RANDOM_ITEMS = 1300;
  localparam int                STALL_LIMIT  = 2000;
  localparam int                SAT_RUN      = 280;
  localparam vmmu_pkg::sample_t S_MIN        = 16'sh8000;
  localparam vmmu_pkg::sample_t S_MAX        = 16'sh7fff;
  localparam longint SUM_HI = (longint'(1) <<< (vmmu_pkg::ACC_BITS - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct {
    vmmu_pkg::res_t re;
    vmmu_pkg::res_t im;
    logic           eov;
  } mac_word_t;

  // Tracks mode and running sums, queues the words the block should emit.
  class mac_scoreboard;
    vmmu_pkg::mode_e mode;
    longint          acc_re;
    longint          acc_im;
    mac_word_t       pending_sums[$];
    int              errors;

    function new();
      mode   = vmmu_pkg::MODE_RMUL;
      acc_re = 0;
      acc_im = 0;
      errors = 0;
    endfunction

    function longint clip(longint v);
      if (v > SUM_HI) return SUM_HI;
      if (v < SUM_LO) return SUM_LO;
      return v;
    endfunction

    function void note_element(vmmu_pkg::sample_t ar, vmmu_pkg::sample_t ai,
                               vmmu_pkg::sample_t br, vmmu_pkg::sample_t bi,
                               logic last);
      longint    pr;
      longint    pi;
      mac_word_t w;
      pi = 0;
      if (mode == vmmu_pkg::MODE_RMUL || mode == vmmu_pkg::MODE_RDOT) begin
        pr = clip(longint'(ar) * longint'(br));
      end else begin
        pr = clip(longint'(ar) * longint'(br) - longint'(ai) * longint'(bi));
        pi = clip(longint'(ai) * longint'(br) + longint'(ar) * longint'(bi));
      end
      if (mode == vmmu_pkg::MODE_RMUL || mode == vmmu_pkg::MODE_CMUL) begin
        w.re  = pr[vmmu_pkg::OUT_BITS-1:0];
        w.im  = pi[vmmu_pkg::OUT_BITS-1:0];
        w.eov = last;
        pending_sums.push_back(w);
      end else begin
        acc_re = clip(acc_re + pr);
        if (mode == vmmu_pkg::MODE_CDOT) acc_im = clip(acc_im + pi);
        if (last) begin
          w.re  = acc_re[vmmu_pkg::OUT_BITS-1:0];
          w.im  = (mode == vmmu_pkg::MODE_CDOT) ? acc_im[vmmu_pkg::OUT_BITS-1:0] : '0;
          w.eov = 1'b1;
          pending_sums.push_back(w);
          acc_re = 0;
          acc_im = 0;
        end
      end
    endfunction

    function void check_word(vmmu_pkg::res_t re, vmmu_pkg::res_t im, logic eov);
      mac_word_t w;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected word re=%0d im=%0d eov=%0b", $time, re, im, eov);
        errors++;
        return;
      end
      w = pending_sums.pop_front();
      if (re !== w.re) begin
        $display("%0t: res_re expected %0d actual %0d", $time, w.re, re);
        errors++;
      end
      if (im !== w.im) begin
        $display("%0t: res_im expected %0d actual %0d", $time, w.im, im);
        errors++;
      end
      if (eov !== w.eov) begin
        $display("%0t: end_of_vector expected %0b actual %0b", $time, w.eov, eov);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  bit            steady = 1'b0;
  int            idle_cycles = 0;
  mac_scoreboard sb;

  vmmu_cfg_if cfg_bus ();
  vmmu_in_if  in_bus ();
  vmmu_out_if out_bus ();

  vector_mac_multiply_unit_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_bus.ready <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check_word(out_bus.res_re, out_bus.res_im, out_bus.end_of_vector);
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_vector_mac_multiply_unit_top: FAIL");
      $finish;
    end
  end

  function automatic vmmu_pkg::sample_t pick_sample();
    case ($urandom_range(9))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return '0;
      3:       return '1;
      default: return vmmu_pkg::sample_t'($urandom_range(65535));
    endcase
  endfunction

  // Call right after a rising edge; returns at the edge that takes the word.
  task automatic send_element(vmmu_pkg::sample_t ar, vmmu_pkg::sample_t ai,
                              vmmu_pkg::sample_t br, vmmu_pkg::sample_t bi,
                              logic last);
    while (!steady && $urandom_range(99) < 24) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.a_re  <= ar;
    in_bus.a_im  <= ai;
    in_bus.b_re  <= br;
    in_bus.b_im  <= bi;
    in_bus.last  <= last;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_element(ar, ai, br, bi, last);
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_sums.size() != 0);
  endtask

  // Block must be idle: drain, then let the pipeline settle past its latency.
  task automatic write_mode(vmmu_pkg::mode_e m);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= m;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    int              sent;
    int              phase;
    int              n;
    int              vec_left;
    vmmu_pkg::mode_e m;
    sb = new();
    rst_ni        <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= vmmu_pkg::MODE_RMUL;
    in_bus.valid  <= 1'b0;
    in_bus.a_re   <= '0;
    in_bus.a_im   <= '0;
    in_bus.b_re   <= '0;
    in_bus.b_im   <= '0;
    in_bus.last   <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // real multiply straight out of reset, imaginary parts must be ignored
    send_element(S_MIN, S_MAX, S_MIN, S_MIN, 1'b0);
    send_element(S_MAX, S_MIN, S_MAX, S_MAX, 1'b0);
    send_element(S_MIN, '0, S_MAX, '1, 1'b1);
    send_element('0, 16'sd12345, '1, S_MAX, 1'b0);

    write_mode(vmmu_pkg::MODE_CMUL);
    send_element(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
    send_element(S_MIN, S_MIN, S_MIN, S_MAX, 1'b1);
    send_element(S_MAX, S_MIN, S_MIN, S_MAX, 1'b0);

    write_mode(vmmu_pkg::MODE_RDOT);
    send_element(S_MIN, S_MAX, S_MIN, S_MAX, 1'b0);
    send_element(S_MAX, S_MIN, S_MAX, S_MIN, 1'b0);
    send_element(S_MIN, 16'sd5, S_MAX, 16'sd7, 1'b1);
    send_element('1, '1, '1, '1, 1'b1);

    write_mode(vmmu_pkg::MODE_CDOT);
    send_element(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
    send_element(S_MAX, S_MAX, S_MIN, S_MAX, 1'b0);
    send_element(16'sd100, -16'sd200, 16'sd300, -16'sd400, 1'b1);

    // mode changes mid-vector: sums survive until a dot-mode last word
    write_mode(vmmu_pkg::MODE_RDOT);
    send_element(16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000, 1'b0);
    send_element(S_MIN, 16'sd9, S_MIN, 16'sd9, 1'b0);
    write_mode(vmmu_pkg::MODE_CMUL);
    send_element(16'sd7, 16'sd8, 16'sd9, 16'sd10, 1'b1);
    write_mode(vmmu_pkg::MODE_CDOT);
    send_element(16'sd3, 16'sd4, 16'sd5, 16'sd6, 1'b0);
    write_mode(vmmu_pkg::MODE_RDOT);
    send_element(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1);
    write_mode(vmmu_pkg::MODE_CDOT);
    send_element(16'sd11, -16'sd13, 16'sd17, 16'sd19, 1'b1);

    sent     = 0;
    phase    = 0;
    vec_left = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0:       m = vmmu_pkg::MODE_RMUL;
        1, 2:    m = vmmu_pkg::MODE_CDOT;
        default: m = vmmu_pkg::mode_e'($urandom_range(3));
      endcase
      steady = (phase == 4);
      write_mode(m);
      if (phase == 2) begin
        // drive the real sum into its upper clamp, then the imaginary one into its lower
        for (int k = 0; k < 2 * SAT_RUN; k++) begin
          if (k < SAT_RUN) begin
            send_element(S_MIN, S_MIN, S_MIN,
                         S_MAX - vmmu_pkg::sample_t'($urandom_range(7)), 1'b0);
          end else begin
            send_element(S_MIN, S_MIN, S_MAX - vmmu_pkg::sample_t'($urandom_range(7)),
                         S_MAX, k == 2 * SAT_RUN - 1);
          end
        end
        sent += 2 * SAT_RUN;
      end else begin
        n = $urandom_range(40, 120);
        for (int k = 0; k < n; k++) begin
          if (vec_left == 0) vec_left = $urandom_range(1, 12);
          vec_left--;
          send_element(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                       vec_left == 0);
          if ($urandom_range(59) == 0) wait_for_results();
        end
        sent += n;
      end
      phase++;
    end
    steady = 1'b0;

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_sums.size() == 0) begin
      $display("tb_vector_mac_multiply_unit_top: PASS");
    end else begin
      $display("tb_vector_mac_multiply_unit_top: FAIL");
    end
    $finish;
  end

endmodule
